>>> rtl/i2cm_pkg.sv
// Package for the I2C master with shared byte ring.
// Holds item types, mode, status, register and phase codes; no dependencies.
package i2cm_pkg;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_START  = 3'd1,
		MODE_STATUS = 3'd2,
		MODE_PUSH   = 3'd3,
		MODE_POP    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_TARGET_ADDR = 3'd0,
		REG_WRITE_LEN   = 3'd1,
		REG_READ_LEN    = 3'd2,
		REG_SCL_HIGH    = 3'd3,
		REG_STRETCH_TO  = 3'd4
	} reg_idx_t;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_OK      = 3'd1;
	localparam logic [2:0] ST_OUT_LOW = 3'd2;
	localparam logic [2:0] ST_IN_HIGH = 3'd3;
	localparam logic [2:0] ST_NAK     = 3'd4;
	localparam logic [2:0] ST_BADLEN  = 3'd5;

	localparam logic [11:0] BLOCK_LEN = 12'hFFF;

	typedef enum logic [10:0] {
		PH_IDLE      = 11'b000_0000_0001,
		PH_START     = 11'b000_0000_0010,
		PH_ADDR      = 11'b000_0000_0100,
		PH_SEND      = 11'b000_0000_1000,
		PH_AWAIT_OUT = 11'b000_0001_0000,
		PH_REPSTART  = 11'b000_0010_0000,
		PH_ADDR2     = 11'b000_0100_0000,
		PH_RECV      = 11'b000_1000_0000,
		PH_AWAIT_IN  = 11'b001_0000_0000,
		PH_STOP      = 11'b010_0000_0000,
		PH_ERROR     = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] push_data;
		logic       sda_in;
		logic       scl_in;
	} item_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic [2:0] status_code;
		logic [6:0] in_count;
		logic [6:0] out_space;
		logic [7:0] pop_data;
		logic       irq;
		logic       access_error;
	} result_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [23:0] wdata;
	} cfg_t;

endpackage

>>> rtl/i2cm_item_if.sv
// Input item channel: valid/ready handshake carrying one item_t.
// Depends on i2cm_pkg.
interface i2cm_item_if import i2cm_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> rtl/i2cm_result_if.sv
// Result channel: valid/ready handshake carrying one result_t.
// Depends on i2cm_pkg.
interface i2cm_result_if import i2cm_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> rtl/i2cm_cfg_if.sv
// Register write channel: valid/ready handshake carrying index and write data.
// Depends on i2cm_pkg.
interface i2cm_cfg_if import i2cm_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> rtl/i2cm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read during write to the same address returns old data.
module i2cm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/i2c_master_with_shared_fifo.sv
// I2C master with one byte ring shared by the transmit and receive queues.
// Depends on i2cm_pkg, the three channel interfaces and i2cm_ram.
//
// Usage:
//   item   - one transfer per item: a timing tick (mode 0), a start command,
//            a status read, a byte push or a byte pop. sda_in/scl_in are the
//            sampled bus lines and matter on ticks only.
//   result - exactly one transfer per item, in order: line drivers, status
//            (on a status read), queue levels, popped byte, irq, access error.
//   cfg    - register writes, always ready; write only while no item is in
//            flight. Indexes past the last register are dropped.
// Timing: an item's result is registered in stage one, then in the output register;
// one item per cycle is sustained while results drain. The ring read port is
// registered, so a result's popped byte is picked up as its item leaves stage one,
// and a byte fetched for sending is forwarded into the shifter for the very next item.
// Bus timing is counted in ticks: a bit slot is ceil(H/2) + H + floor(H/2) + 3
// ticks plus any clock stretching, where H is the SCL high time register.
// Reset: bus released, engine idle, queues empty, registers at defaults.
// Output stall: the output register holds the result; a second item waits in
// stage one, and the item channel drops ready until the output drains.
module i2c_master_with_shared_fifo import i2cm_pkg::*; #(
	parameter int BUF_DEPTH = 128,
	parameter int HIGH_MARK = 120
) (
	input  logic            clk,
	input  logic            arst_n,
	i2cm_item_if.sink       item,
	i2cm_result_if.source   result,
	i2cm_cfg_if.sink        cfg
);
	localparam int PW = $clog2(BUF_DEPTH);

	// configuration registers
	logic [7:0]  target_addr_q;
	logic [11:0] write_len_q;
	logic [11:0] read_len_q;
	logic [15:0] scl_high_q;
	logic [23:0] stretch_to_q;

	// engine state
	phase_t      phase_q, ph_d;
	logic [1:0]  step_q, step_d;
	logic [3:0]  bit_q, bit_d;
	logic [23:0] dly_q, dly_d;
	logic        stretch_q, stretch_d;
	logic        scl_q, scl_d, sda_q, sda_d;
	logic [7:0]  shift_q, shift_d, shift_eff;
	logic        shift_ld_q, shift_ld_d;
	logic [11:0] bc_q, bc_d;
	logic [2:0]  held_q, held_d;
	logic        blk_q, blk_d;
	logic [11:0] erl_q, erl_d;
	logic        irq_q, irq_d;
	logic [PW-1:0] out_head_q, out_head_d, out_tail_q, out_tail_d;
	logic [PW-1:0] in_head_q, in_head_d, in_tail_q, in_tail_d;

	// ring access
	logic          ram_we, ram_re;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata, rdata_eff;
	logic          fwd_q;
	logic [7:0]    fwd_data_q;

	// pipeline
	logic    valid_s1, valid_s2;
	result_t res_s1, res_s2;
	logic    pop_s1;
	logic    s1_adv, acc;
	result_t res_d;
	logic    pop_d;

	// per-item scratch
	logic [2:0]  status_out;
	logic        err;
	logic        f_stop, f_send, f_after_write, f_read;
	logic [2:0]  stop_code;
	logic [23:0] lu, ld, hh, wait_dly, wait_nx;
	logic        wait_hi, wait_to, rx;
	logic [7:0]  rx_byte;
	logic [11:0] bc_n;
	logic [PW-1:0] tail_n, sp;
	logic [12:0] togo, cnt13;
	logic [PW+6:0] in_cnt_x, out_sp_x;

	function automatic logic [PW-1:0] ring_cnt(logic [PW-1:0] h, logic [PW-1:0] t);
		return h - t;
	endfunction

	function automatic logic [PW-1:0] ring_space(logic [PW-1:0] h, logic [PW-1:0] t);
		return t - h - PW'(1);
	endfunction

	assign acc       = item.valid && item.ready;
	assign s1_adv    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || s1_adv;
	assign cfg.ready = 1'b1;
	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	assign rdata_eff = fwd_q ? fwd_data_q : ram_rdata;
	assign shift_eff = shift_ld_q ? rdata_eff : shift_q;

	assign hh = {8'd0, scl_high_q};
	assign lu = {7'd0, ({1'b0, scl_high_q} + 17'd1) >> 1};
	assign ld = {9'd0, scl_high_q[15:1]};

	// SCL release and stretch sampling, shared by every wait point
	assign wait_dly = stretch_q ? dly_q : 24'd0;
	assign wait_hi  = item.data.scl_in;
	assign wait_to  = !item.data.scl_in && (wait_dly >= stretch_to_q);
	assign wait_nx  = wait_dly + 24'd1;
	assign rx       = (phase_q == PH_RECV);

	always_comb begin
		ph_d       = phase_q;
		step_d     = step_q;
		bit_d      = bit_q;
		dly_d      = dly_q;
		stretch_d  = stretch_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		shift_d    = shift_eff;
		shift_ld_d = 1'b0;
		bc_d       = bc_q;
		held_d     = held_q;
		blk_d      = blk_q;
		erl_d      = erl_q;
		irq_d      = irq_q;
		out_head_d = out_head_q;
		out_tail_d = out_tail_q;
		in_head_d  = in_head_q;
		in_tail_d  = in_tail_q;
		ram_we     = 1'b0;
		ram_waddr  = out_head_q;
		ram_wdata  = item.data.push_data;
		ram_re     = 1'b0;
		ram_raddr  = in_tail_q;
		status_out = ST_NONE;
		err        = 1'b0;
		pop_d      = 1'b0;
		f_stop     = 1'b0;
		f_send     = 1'b0;
		f_after_write = 1'b0;
		f_read     = 1'b0;
		stop_code  = ST_OK;
		rx_byte    = {shift_eff[6:0], item.data.sda_in};
		bc_n       = bc_q + 12'd1;
		tail_n     = out_tail_q + PW'(1);
		sp         = '0;
		togo       = 13'd0;
		cnt13      = 13'd0;

		unique case (item.data.mode)
		MODE_TICK: begin
			if (!stretch_q && dly_q != 24'd0) begin
				dly_d = dly_q - 24'd1;
			end else begin
				unique case (phase_q)
				PH_START: begin
					if (step_q == 2'd0) begin
						sda_d  = 1'b1;
						dly_d  = hh;
						step_d = 2'd1;
					end else begin
						scl_d   = 1'b1;
						dly_d   = ld;
						shift_d = target_addr_q |
							{7'd0, (read_len_q != 12'd0) && (write_len_q == 12'd0)};
						ph_d    = PH_ADDR;
						step_d  = 2'd0;
						bit_d   = 4'd0;
					end
				end
				PH_ADDR, PH_SEND, PH_ADDR2, PH_RECV: begin
					if (step_q == 2'd0) begin
						if (!bit_q[3]) begin
							sda_d = rx ? 1'b0 : !shift_eff[3'd7 - bit_q[2:0]];
						end else begin
							sda_d = rx && (bc_q != erl_q);
						end
						dly_d  = lu;
						step_d = 2'd1;
					end else if (step_q == 2'd1) begin
						scl_d = 1'b0;
						if (wait_hi) begin
							stretch_d = 1'b0;
							dly_d     = hh;
							step_d    = 2'd2;
						end else if (wait_to) begin
							stretch_d = 1'b0;
							dly_d     = 24'd0;
							if (phase_q == PH_SEND) begin
								out_tail_d = out_head_q;
							end
							f_stop    = 1'b1;
							stop_code = ST_NAK;
						end else begin
							stretch_d = 1'b1;
							dly_d     = wait_nx;
						end
					end else begin
						scl_d = 1'b1;
						dly_d = ld;
						if (!bit_q[3]) begin
							step_d = 2'd0;
							bit_d  = bit_q + 4'd1;
							if (rx) begin
								shift_d = rx_byte;
								if (bit_q == 4'd7) begin
									// received byte complete: store it, check block length
									ram_we    = 1'b1;
									ram_waddr = in_head_q;
									ram_wdata = rx_byte;
									if (blk_q && (16'(rx_byte) >
										16'(ring_space(in_head_q, in_tail_q)))) begin
										f_stop    = 1'b1;
										stop_code = ST_BADLEN;
									end else begin
										if (blk_q) begin
											blk_d = 1'b0;
											erl_d = {4'd0, rx_byte};
										end
										bc_d = (blk_q ? 12'd0 : bc_q) + 12'd1;
									end
								end
							end
						end else begin
							// acknowledge slot
							priority case (1'b1)
							(phase_q == PH_ADDR): begin
								if (item.data.sda_in) begin
									f_stop = 1'b1;
									stop_code = ST_NAK;
								end else if (write_len_q == 12'd0) begin
									f_after_write = 1'b1;
								end else begin
									bc_d   = 12'd0;
									f_send = 1'b1;
								end
							end
							(phase_q == PH_ADDR2): begin
								if (item.data.sda_in) begin
									f_stop = 1'b1;
									stop_code = ST_NAK;
								end else begin
									f_read = 1'b1;
								end
							end
							(phase_q == PH_SEND): begin
								if (item.data.sda_in) begin
									out_tail_d = out_head_q;
									f_stop     = 1'b1;
									stop_code  = ST_NAK;
								end else begin
									bc_d       = bc_n;
									out_tail_d = tail_n;
									if (bc_n == write_len_q) begin
										out_tail_d    = out_head_q;
										f_after_write = 1'b1;
									end else begin
										if (out_head_q == tail_n && bc_n < write_len_q) begin
											held_d = ST_OUT_LOW;
											irq_d  = 1'b1;
										end
										f_send = 1'b1;
									end
								end
							end
							default: begin
								in_head_d = in_head_q + PW'(1);
								if (bc_q == erl_q) begin
									f_stop    = 1'b1;
									stop_code = ST_OK;
								end else begin
									sp = ring_space(in_head_d, in_tail_q);
									if (sp == PW'(HIGH_MARK)) begin
										held_d = ST_IN_HIGH;
										irq_d  = 1'b1;
									end
									step_d = 2'd0;
									bit_d  = 4'd0;
									ph_d   = (sp != '0) ? PH_RECV : PH_AWAIT_IN;
								end
							end
							endcase
						end
					end
				end
				PH_REPSTART: begin
					unique case (step_q)
					2'd0: begin
						sda_d  = 1'b0;
						dly_d  = lu;
						step_d = 2'd1;
					end
					2'd1: begin
						scl_d = 1'b0;
						if (wait_hi) begin
							stretch_d = 1'b0;
							dly_d     = hh;
							step_d    = 2'd2;
						end else if (wait_to) begin
							stretch_d = 1'b0;
							dly_d     = 24'd0;
							f_stop    = 1'b1;
							stop_code = ST_NAK;
						end else begin
							stretch_d = 1'b1;
							dly_d     = wait_nx;
						end
					end
					2'd2: begin
						sda_d  = 1'b1;
						dly_d  = hh;
						step_d = 2'd3;
					end
					default: begin
						scl_d   = 1'b1;
						dly_d   = ld;
						shift_d = target_addr_q | 8'h01;
						ph_d    = PH_ADDR2;
						step_d  = 2'd0;
						bit_d   = 4'd0;
					end
					endcase
				end
				PH_STOP: begin
					if (step_q == 2'd0) begin
						sda_d  = 1'b1;
						dly_d  = lu;
						step_d = 2'd1;
					end else if (step_q == 2'd1) begin
						scl_d = 1'b0;
						if (wait_hi) begin
							stretch_d = 1'b0;
							dly_d     = hh;
							step_d    = 2'd2;
						end else if (wait_to) begin
							// timeout inside STOP: finish the STOP anyway
							stretch_d = 1'b0;
							dly_d     = hh;
							step_d    = 2'd2;
						end else begin
							stretch_d = 1'b1;
							dly_d     = wait_nx;
						end
					end else begin
						sda_d  = 1'b0;
						dly_d  = hh;
						held_d = shift_eff[2:0];
						irq_d  = 1'b1;
						ph_d   = (shift_eff == {5'd0, ST_OK}) ? PH_IDLE : PH_ERROR;
						step_d = 2'd0;
						bit_d  = 4'd0;
					end
				end
				default: ;
				endcase
			end
		end
		MODE_START: begin
			if (phase_q == PH_IDLE) begin
				ph_d   = PH_START;
				step_d = 2'd0;
				bit_d  = 4'd0;
			end
		end
		MODE_STATUS: begin
			status_out = held_q;
			held_d     = ST_NONE;
			irq_d      = 1'b0;
			if (phase_q == PH_ERROR) begin
				ph_d = PH_IDLE;
			end
		end
		MODE_PUSH: begin
			if (ring_space(out_head_q, out_tail_q) == '0) begin
				err = 1'b1;
			end else begin
				ram_we     = 1'b1;
				ram_waddr  = out_head_q;
				ram_wdata  = item.data.push_data;
				out_head_d = out_head_q + PW'(1);
				if (phase_q == PH_AWAIT_OUT) begin
					// resume once min(bytes to go, high mark) are queued
					togo  = {1'b0, write_len_q} - {1'b0, bc_q};
					cnt13 = 13'(ring_cnt(out_head_d, out_tail_q));
					if (bc_q >= write_len_q || cnt13 >= togo ||
						cnt13 >= 13'(HIGH_MARK)) begin
						f_send = 1'b1;
					end
				end
			end
		end
		MODE_POP: begin
			if (ring_cnt(in_head_q, in_tail_q) == '0) begin
				err = 1'b1;
			end else begin
				ram_re    = 1'b1;
				ram_raddr = in_tail_q;
				pop_d     = 1'b1;
				in_tail_d = in_tail_q + PW'(1);
				if (phase_q == PH_AWAIT_IN) begin
					ph_d   = PH_RECV;
					step_d = 2'd0;
					bit_d  = 4'd0;
				end
			end
		end
		default: ;
		endcase

		if (f_after_write) begin
			if (read_len_q == 12'd0) begin
				f_stop    = 1'b1;
				stop_code = ST_OK;
			end else if (write_len_q == 12'd0) begin
				f_read = 1'b1;
			end else begin
				ph_d   = PH_REPSTART;
				step_d = 2'd0;
				bit_d  = 4'd0;
			end
		end
		if (f_read) begin
			bc_d   = 12'd0;
			blk_d  = (read_len_q == BLOCK_LEN);
			erl_d  = read_len_q;
			step_d = 2'd0;
			bit_d  = 4'd0;
			ph_d   = (ring_space(in_head_d, in_tail_d) == '0) ? PH_AWAIT_IN : PH_RECV;
		end
		if (f_send) begin
			step_d = 2'd0;
			bit_d  = 4'd0;
			if (ring_cnt(out_head_d, out_tail_d) == '0) begin
				ph_d = PH_AWAIT_OUT;
			end else begin
				// fetch the next byte; it lands in the shifter for the next item
				ram_re     = 1'b1;
				ram_raddr  = out_tail_d;
				shift_ld_d = 1'b1;
				ph_d       = PH_SEND;
			end
		end
		if (f_stop) begin
			shift_d = {5'd0, stop_code};
			ph_d    = PH_STOP;
			step_d  = 2'd0;
			bit_d   = 4'd0;
		end

		in_cnt_x = {7'd0, ring_cnt(in_head_d, in_tail_d)};
		out_sp_x = {7'd0, ring_space(out_head_d, out_tail_d)};
		res_d.scl_drive_low = scl_d;
		res_d.sda_drive_low = sda_d;
		res_d.status_code   = status_out;
		res_d.in_count      = in_cnt_x[6:0];
		res_d.out_space     = out_sp_x[6:0];
		res_d.pop_data      = 8'd0;
		res_d.irq           = irq_d;
		res_d.access_error  = err;
	end

	i2cm_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we && acc),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re && acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// forward a byte written in the same cycle it is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (acc && ram_re) begin
			fwd_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && ram_re) begin
			fwd_data_q <= ram_wdata;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_addr_q <= 8'd0;
			write_len_q   <= 12'd0;
			read_len_q    <= 12'd0;
			scl_high_q    <= 16'd5;
			stretch_to_q  <= 24'd100000;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
			REG_TARGET_ADDR: target_addr_q <= cfg.data.wdata[7:0];
			REG_WRITE_LEN:   write_len_q   <= cfg.data.wdata[11:0];
			REG_READ_LEN:    read_len_q    <= cfg.data.wdata[11:0];
			REG_SCL_HIGH:    scl_high_q    <= cfg.data.wdata[15:0];
			REG_STRETCH_TO:  stretch_to_q  <= cfg.data.wdata;
			default: ;
			endcase
		end
	end

	// engine state: advance on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			step_q     <= 2'd0;
			bit_q      <= 4'd0;
			dly_q      <= 24'd0;
			stretch_q  <= 1'b0;
			scl_q      <= 1'b0;
			sda_q      <= 1'b0;
			shift_q    <= 8'd0;
			shift_ld_q <= 1'b0;
			bc_q       <= 12'd0;
			held_q     <= ST_NONE;
			blk_q      <= 1'b0;
			erl_q      <= 12'd0;
			irq_q      <= 1'b0;
			out_head_q <= '0;
			out_tail_q <= '0;
			in_head_q  <= '0;
			in_tail_q  <= '0;
		end else if (acc) begin
			phase_q    <= ph_d;
			step_q     <= step_d;
			bit_q      <= bit_d;
			dly_q      <= dly_d;
			stretch_q  <= stretch_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			shift_q    <= shift_d;
			shift_ld_q <= shift_ld_d;
			bc_q       <= bc_d;
			held_q     <= held_d;
			blk_q      <= blk_d;
			erl_q      <= erl_d;
			irq_q      <= irq_d;
			out_head_q <= out_head_d;
			out_tail_q <= out_tail_d;
			in_head_q  <= in_head_d;
			in_tail_q  <= in_tail_d;
		end
	end

	// result pipeline: stage one waits for the ring read, stage two is the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_d;
			pop_s1 <= pop_d;
		end
		if (s1_adv) begin
			res_s2          <= res_s1;
			res_s2.pop_data <= pop_s1 ? rdata_eff : 8'd0;
		end
	end

`ifndef SYNTHESIS
	// a byte in flight always has its source still queued
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEND) |-> (out_head_q != out_tail_q))
		else $error("send phase with empty transmit queue");

	// receiving only with room for the byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECV) |-> (ring_space(in_head_q, in_tail_q) != '0))
		else $error("receive phase with full receive queue");

	// pending shifter load belongs to a send
	assert property (@(posedge clk) disable iff (!arst_n)
		shift_ld_q |-> (phase_q == PH_SEND))
		else $error("shifter load pending outside send phase");

	// a pending shifter load and a pending pop never share the read register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && pop_s1) |-> !shift_ld_q)
		else $error("read data claimed by pop and shifter");
`endif

endmodule
